@@ rtl/shc_pkg.sv @@
// ----------------------------------------------------------------------------
// SECDED Hamming (32,26) codec package
// Shared types, code position tables and status codes for the codec stages.
// ----------------------------------------------------------------------------
package shc_pkg;

   // Item kinds carried on the request channel.
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_CLEAN  = 2'd0;
   localparam logic [1:0] ST_FIXED  = 2'd1;
   localparam logic [1:0] ST_DOUBLE = 2'd2;

   // Reference mask after reset: only the top bit is tested.
   localparam logic [31:0] MASK_RESET = 32'h8000_0000;

   // Code positions of the 24 data bits, first (most significant) data bit first.
   localparam logic [4:0] DATA_POS [24] = '{
      5'd6,  5'd7,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
      5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
      5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
   };

   // Positions that hold the two chunk index bits.
   localparam logic [4:0] IDX_HI_POS = 5'd3;
   localparam logic [4:0] IDX_LO_POS = 5'd5;

   // For syndrome bit k, the set of code positions whose index has bit k set.
   localparam logic [31:0] SYN_SEL [5] = '{
      32'hAAAA_AAAA, 32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_0000
   };

   // Positional vector after the first stage: bit p is code position p.
   typedef struct packed {
      logic        cmd;
      logic [31:0] pos;
   } shc_vec_type;

   // Positional vector with its syndrome and overall parity.
   typedef struct packed {
      logic        cmd;
      logic [31:0] pos;
      logic [4:0]  syn;
      logic        par;
   } shc_syn_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] data_out;
      logic [31:0] code_word;
   } shc_rsp_type;

endpackage

@@ rtl/secded_hamming_32_26_codec.sv @@
// ----------------------------------------------------------------------------
// SECDED Hamming (32,26) codec
// Each request item passes the placement, syndrome and finishing stage registers
// in turn. Throughput: one item per cycle while rsp_tready is high, through a
// three-stage pipeline, each stage with its own valid bit and handshake.
// Reset (synchronous, active high) empties the pipeline and sets the
// reference mask to 0x80000000.
// ----------------------------------------------------------------------------
module secded_hamming_32_26_codec import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] payload, [33:32] chunk_index, rest zero
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] code_word, [55:32] data_out,
                                    // [57:56] status, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // reference_mask
);

   logic [31:0] mask_ff;
   logic [31:0] mask_in;
   logic        vec_valid;
   logic        vec_ready;
   shc_vec_type vec_data;
   logic        syn_valid;
   logic        syn_ready;
   shc_syn_type syn_data;
   shc_rsp_type rsp_data;

   // Reference mask register; writes are always taken.
   assign csr_ready = 1'b1;
   assign mask_in   = (csr_valid && csr_ready) ? csr_data : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // Pipeline stages.
   shc_place u_place (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .cmd         (req_tuser),
      .payload     (req_tdata[31:0]),
      .chunk_index (req_tdata[33:32]),
      .mask        (mask_ff),
      .out_valid   (vec_valid),
      .out_ready   (vec_ready),
      .out_data    (vec_data)
   );

   shc_syndrome u_syndrome (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vec_valid),
      .in_ready  (vec_ready),
      .in_data   (vec_data),
      .out_valid (syn_valid),
      .out_ready (syn_ready),
      .out_data  (syn_data)
   );

   shc_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (syn_valid),
      .in_ready  (syn_ready),
      .in_data   (syn_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // Response packing.
   assign rsp_tdata = {6'd0, rsp_data.status, rsp_data.data_out, rsp_data.code_word};

endmodule

@@ rtl/shc_place.sv @@
// ----------------------------------------------------------------------------
// Code position placement stage
// Builds the positional vector: data and chunk bits for encode, the word
// unpacked through the reference mask for decode.
// ----------------------------------------------------------------------------
module shc_place import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        cmd,
   input  logic [31:0] payload,
   input  logic [1:0]  chunk_index,
   input  logic [31:0] mask,
   output logic        out_valid,
   input  logic        out_ready,
   output shc_vec_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   shc_vec_type data_ff;
   shc_vec_type data_in;
   logic [31:0] enc_pos;
   logic [31:0] dec_pos;

   // Encode: scatter data bits and chunk index bits to their code positions.
   always_comb begin
      enc_pos = '0;
      for (int i = 0; i < 24; i++) begin
         enc_pos[DATA_POS[i]] = payload[5'(23 - i)];
      end
      enc_pos[IDX_HI_POS] = chunk_index[1];
      enc_pos[IDX_LO_POS] = chunk_index[0];
   end

   // Decode: position i is one when the word shifted left by i meets the mask.
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         dec_pos[i] = |((payload << i) & mask);
      end
   end

   // Stage register handshake.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.cmd = cmd;
      data_in.pos = (cmd == CMD_DECODE) ? dec_pos : enc_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/shc_syndrome.sv @@
// ----------------------------------------------------------------------------
// Syndrome stage
// Forms the XOR syndrome of the set positions and the overall parity. On
// encode the syndrome bits are exactly the Hamming parity bits.
// ----------------------------------------------------------------------------
module shc_syndrome import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  shc_vec_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output shc_syn_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   shc_syn_type data_ff;
   shc_syn_type data_in;

   // Each syndrome bit is the parity of the positions whose index has that bit.
   always_comb begin
      data_in.cmd = in_data.cmd;
      data_in.pos = in_data.pos;
      for (int k = 0; k < 5; k++) begin
         data_in.syn[k] = ^(in_data.pos & SYN_SEL[k]);
      end
      data_in.par = ^in_data.pos;
   end

   // Stage register handshake.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/shc_finish.sv @@
// ----------------------------------------------------------------------------
// Finishing stage
// Encode: inserts parity bits and maps positions to word bits. Decode:
// corrects a single error, extracts the data bits and sets the status.
// ----------------------------------------------------------------------------
module shc_finish import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  shc_syn_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output shc_rsp_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   shc_rsp_type data_ff;
   shc_rsp_type data_in;
   logic [31:0] full_pos;
   logic [31:0] code_word;
   logic [31:0] corr_pos;
   logic [23:0] data_bits;
   logic [1:0]  status;

   // Encode: parity bits go to positions 1, 2, 4, 8 and 16; position 0 makes
   // the whole word even, then position p lands in word bit 31-p.
   always_comb begin
      full_pos     = in_data.pos;
      full_pos[1]  = in_data.syn[0];
      full_pos[2]  = in_data.syn[1];
      full_pos[4]  = in_data.syn[2];
      full_pos[8]  = in_data.syn[3];
      full_pos[16] = in_data.syn[4];
      full_pos[0]  = in_data.par ^ (^in_data.syn);
      for (int p = 0; p < 32; p++) begin
         code_word[5'(31 - p)] = full_pos[p];
      end
   end

   // Decode: odd overall parity flips the position the syndrome points at.
   always_comb begin
      corr_pos = in_data.pos;
      if (in_data.par) begin
         corr_pos[in_data.syn] = ~in_data.pos[in_data.syn];
         status = ST_FIXED;
      end else if (in_data.syn != 5'd0) begin
         status = ST_DOUBLE;
      end else begin
         status = ST_CLEAN;
      end
      for (int i = 0; i < 24; i++) begin
         data_bits[5'(23 - i)] = corr_pos[DATA_POS[i]];
      end
   end

   always_comb begin
      if (in_data.cmd == CMD_DECODE) begin
         data_in.code_word = '0;
         data_in.data_out  = data_bits;
         data_in.status    = status;
      end else begin
         data_in.code_word = code_word;
         data_in.data_out  = '0;
         data_in.status    = ST_CLEAN;
      end
   end

   // Output register handshake.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
